>>> hdl/ksam_pkg.sv
`timescale 1ns / 1ps

package ksam_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int COMMAND_W = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 6;

    // key and value packed without gaps, already a whole number of bytes
    localparam int S_TDATA_W = KEY_W + VALUE_W;
    localparam int M_FIELD_W = INDEX_W + KEY_W + VALUE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [KEY_W-1:0]          key_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [COMMAND_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_MERGE = 2'd2,
        CMD_DRAIN = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_APPENDED = 3'd0,
        STAT_ACCUM    = 3'd1,
        STAT_DROPPED  = 3'd2,
        STAT_READ     = 3'd3,
        STAT_EMPTY    = 3'd4,
        STAT_CLEARED  = 3'd5
    } status_t;

    // kind of result the datapath produces when told to emit
    typedef enum logic [2:0] {
        EMIT_CLEAR,
        EMIT_APPEND,
        EMIT_ACCUM,
        EMIT_READ,
        EMIT_EMPTY
    } emit_t;

    typedef struct packed {
        logic  capture;    // take the input transfer into the operand registers
        logic  ptr_clear;  // restart the scan pointer at entry 0
        logic  rd_en;      // read the table at the scan pointer and advance it
        logic  emit;       // load the output register and apply the table update
        emit_t kind;
    } ctl_cmd_t;

    typedef struct packed {
        logic full;        // entry count at table depth
        logic empty;       // no entries
        logic at_base;     // scan pointer reached the base count
        logic at_count;    // scan pointer reached the entry count
        logic key_match;   // last read key equals the operand key
        logic out_free;    // output register can take a result this cycle
    } ctl_sts_t;

endpackage

>>> hdl/ksam_ctrl.sv
`timescale 1ns / 1ps

module ksam_ctrl import ksam_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  cmd_t     in_command,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_DRAIN,
        S_DOUT
    } state_t;

    state_t state_reg, state_next;
    emit_t  kind_reg, kind_next;
    logic   pend_reg, pend_next;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        pend_next     = pend_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.ptr_clear = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = kind_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture   = 1'b1;
                    cmd.ptr_clear = 1'b1;
                    pend_next     = 1'b0;
                    case (in_command)
                        CMD_CLEAR: begin
                            kind_next  = EMIT_CLEAR;
                            state_next = S_FIN;
                        end
                        CMD_LOAD: begin
                            kind_next  = EMIT_APPEND;
                            state_next = S_FIN;
                        end
                        CMD_MERGE: begin
                            state_next = S_SCAN;
                        end
                        CMD_DRAIN: begin
                            if (sts.empty) begin
                                kind_next  = EMIT_EMPTY;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_DRAIN;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // hold the read data on a hit: no new read may overwrite it
                if (pend_reg && sts.key_match) begin
                    kind_next  = EMIT_ACCUM;
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end else if (!sts.at_base) begin
                    cmd.rd_en = 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    kind_next  = EMIT_APPEND;
                    state_next = S_FIN;
                end else begin
                    pend_next = 1'b0;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN: begin
                cmd.rd_en  = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT: begin
                cmd.kind = EMIT_READ;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.at_count) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= EMIT_CLEAR;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> hdl/ksam_dp.sv
`timescale 1ns / 1ps

module ksam_dp import ksam_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctl_cmd_t            cmd,
    output ctl_sts_t            sts,
    input  logic                cfg_we,
    input  logic                cfg_mode,
    input  cmd_t                in_command,
    input  key_t                in_key,
    input  value_t              in_value,
    input  logic                out_ready,
    output logic                out_valid,
    output status_t             out_status,
    output logic [INDEX_W-1:0]  out_index,
    output key_t                out_key,
    output value_t              out_value,
    output logic                out_last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    key_t   key_mem [TABLE_DEPTH];
    value_t val_mem [TABLE_DEPTH];

    logic               mode_reg;
    cmd_t               cmd_reg;
    key_t               key_reg;
    value_t             val_reg;
    logic [CNT_W-1:0]   entry_cnt_reg, entry_cnt_next;
    logic [CNT_W-1:0]   base_cnt_reg, base_cnt_next;
    logic [CNT_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    key_t               rd_key_reg;
    value_t             rd_val_reg;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    key_t               out_key_reg, out_key_next;
    value_t             out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    value_t             wr_val;

    logic [VALUE_W:0]   acc_wide;
    value_t             acc_val;
    value_t             neg_val;
    value_t             app_val;
    logic               last_read;

    assign sts.full      = (entry_cnt_reg == CNT_W'(TABLE_DEPTH));
    assign sts.empty     = (entry_cnt_reg == '0);
    assign sts.at_base   = (ptr_reg == base_cnt_reg);
    assign sts.at_count  = (ptr_reg == entry_cnt_reg);
    assign sts.key_match = (rd_key_reg == key_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // saturating accumulate: one sign bit of headroom shows the overflow
    always_comb begin
        if (mode_reg) begin
            acc_wide = {rd_val_reg[VALUE_W-1], rd_val_reg} - {val_reg[VALUE_W-1], val_reg};
        end else begin
            acc_wide = {rd_val_reg[VALUE_W-1], rd_val_reg} + {val_reg[VALUE_W-1], val_reg};
        end
        if (acc_wide[VALUE_W] != acc_wide[VALUE_W-1]) begin
            acc_val = acc_wide[VALUE_W] ? VAL_MIN : VAL_MAX;
        end else begin
            acc_val = acc_wide[VALUE_W-1:0];
        end
    end

    assign neg_val   = (val_reg == VAL_MIN) ? VAL_MAX : (VALUE_W'(0) - val_reg);
    assign app_val   = (cmd_reg == CMD_MERGE && mode_reg) ? neg_val : val_reg;
    assign last_read = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == entry_cnt_reg);

    always_comb begin
        entry_cnt_next  = entry_cnt_reg;
        base_cnt_next   = base_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = entry_cnt_reg[IDX_W-1:0];
        wr_val          = app_val;

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            case (cmd.kind)
                EMIT_CLEAR: begin
                    entry_cnt_next  = '0;
                    base_cnt_next   = '0;
                    out_status_next = STAT_CLEARED;
                    out_index_next  = '0;
                    out_key_next    = '0;
                    out_value_next  = '0;
                end
                EMIT_APPEND: begin
                    out_key_next   = key_reg;
                    out_value_next = app_val;
                    if (sts.full) begin
                        out_status_next = STAT_DROPPED;
                        out_index_next  = '0;
                    end else begin
                        wr_en           = 1'b1;
                        entry_cnt_next  = entry_cnt_reg + CNT_W'(1);
                        out_status_next = STAT_APPENDED;
                        out_index_next  = INDEX_W'(entry_cnt_reg[IDX_W-1:0]);
                    end
                    // a load makes every present entry searchable
                    if (cmd_reg == CMD_LOAD) begin
                        base_cnt_next = entry_cnt_next;
                    end
                end
                EMIT_ACCUM: begin
                    wr_en           = 1'b1;
                    wr_addr         = cmp_idx_reg;
                    wr_val          = acc_val;
                    out_status_next = STAT_ACCUM;
                    out_index_next  = INDEX_W'(cmp_idx_reg);
                    out_key_next    = key_reg;
                    out_value_next  = acc_val;
                end
                EMIT_READ: begin
                    out_status_next = STAT_READ;
                    out_index_next  = INDEX_W'(cmp_idx_reg);
                    out_key_next    = rd_key_reg;
                    out_value_next  = rd_val_reg;
                    out_last_next   = last_read;
                end
                EMIT_EMPTY: begin
                    out_status_next = STAT_EMPTY;
                    out_index_next  = '0;
                    out_key_next    = '0;
                    out_value_next  = '0;
                end
                default: begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            entry_cnt_reg <= '0;
            base_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_mode;
            end
            entry_cnt_reg <= entry_cnt_next;
            base_cnt_reg  <= base_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= in_command;
            key_reg <= in_key;
            val_reg <= in_value;
        end
        if (cmd.ptr_clear) begin
            ptr_reg <= '0;
        end else if (cmd.rd_en) begin
            ptr_reg <= ptr_reg + CNT_W'(1);
        end
        if (cmd.rd_en) begin
            cmp_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    // table storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= key_reg;
            val_mem[wr_addr] <= wr_val;
        end
        if (cmd.rd_en) begin
            rd_key_reg <= key_mem[ptr_reg[IDX_W-1:0]];
            rd_val_reg <= val_mem[ptr_reg[IDX_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;

endmodule

>>> hdl/keyed_sparse_accumulate_merge.sv
`timescale 1ns / 1ps

// Key/value table that merges two sparse relations. Each input transfer carries a
// command in s_tuser (clear, load base tuple, merge tuple, drain) and a key and
// Q32.32 value in s_tdata; every command answers with result transfers on the m_
// side, the final one marked by m_tlast. Merges search only the base entries,
// one table read per cycle, and add (or, with subtract mode set over the cfg
// channel, subtract) into the first matching entry, else append. Values saturate
// to the signed 64-bit range. One command is worked on at a time. Clear and load
// go from the transfer through state S_FIN to the registered result; a merge first
// scans the base entries through the single read port of the table memory; a drain
// reads its first entry in state S_DRAIN and then gives one entry per cycle while
// m_tready is high.
// Stored entries are not initialized by reset; only filled positions are read.

module keyed_sparse_accumulate_merge import ksam_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // tuple_key[31:0], tuple_value[95:32]
    input  logic [COMMAND_W-1:0] s_tuser,   // command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // entry_index[5:0], entry_key[37:6],
                                            // entry_value[101:38], zero fill
    output logic [STATUS_W-1:0]  m_tuser,   // status[2:0]
    output logic                 m_tlast,   // last_entry
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data   // subtract_mode
);

    ctl_cmd_t           cmd;
    ctl_sts_t           sts;
    status_t            out_status;
    logic [INDEX_W-1:0] out_index;
    key_t               out_key;
    value_t             out_value;

    assign cfg_ready = 1'b1;

    ksam_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (cmd_t'(s_tuser)),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ksam_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_mode   (cfg_data),
        .in_command (cmd_t'(s_tuser)),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_value   (s_tdata[KEY_W +: VALUE_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_index  (out_index),
        .out_key    (out_key),
        .out_value  (out_value),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_status;
    assign m_tdata = {{(M_TDATA_W - M_FIELD_W){1'b0}}, out_value, out_key, out_index};

    // never overwrite a result that has not been transferred
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register busy");

    // table reads stay inside the filled part
    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !sts.at_count)
        else $error("table read beyond entry count");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in progress");

    // an accumulate result is only emitted while the read key matches the operand key
    a_accum_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.kind == EMIT_ACCUM) |-> sts.key_match)
        else $error("accumulate without key match");

endmodule

>>> verif/keyed_sparse_accumulate_merge_tb.sv
`timescale 1ns / 1ps

module keyed_sparse_accumulate_merge_tb;
    import ksam_pkg::*;

    localparam int DEPTH    = TABLE_DEPTH_DEF;
    localparam int N_RANDOM = 500;

    typedef struct {
        status_t             status;
        logic [INDEX_W-1:0]  position;
        key_t                key;
        value_t              value;
        logic                last;
    } table_result_t;

    // Mirror of the key/value table plus the queue of results it still owes.
    class merge_table_model;
        key_t          key_tbl[DEPTH];
        value_t        val_tbl[DEPTH];
        int            entry_count = 0;
        int            base_count  = 0;
        bit            sub_mode    = 1'b0;
        table_result_t owed_q[$];
        int            n_cmd[4]    = '{0, 0, 0, 0};
        int            n_checked   = 0;
        int            n_mismatch  = 0;
        int            n_dropped   = 0;
        int            n_hits      = 0;
        int            n_sat       = 0;

        task report_mismatch(string msg);
            n_mismatch++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // a + b, or a - b when minus is set, clamped to the signed value range
        function value_t clamp_sum(value_t a, value_t b, bit minus);
            logic signed [VALUE_W:0] wa, wb, s;
            wa = a;
            wb = b;
            s  = minus ? wa - wb : wa + wb;
            if (s[VALUE_W] != s[VALUE_W-1]) begin
                n_sat++;
                return s[VALUE_W] ? VAL_MIN : VAL_MAX;
            end
            return s[VALUE_W-1:0];
        endfunction

        function void owe(status_t st, int pos, key_t k, value_t v, bit last);
            table_result_t r;
            r.status   = st;
            r.position = pos[INDEX_W-1:0];
            r.key      = k;
            r.value    = v;
            r.last     = last;
            owed_q.push_back(r);
        endfunction

        function void store_tuple(key_t k, value_t v);
            if (entry_count >= DEPTH) begin
                n_dropped++;
                owe(STAT_DROPPED, 0, k, v, 1'b1);
            end else begin
                key_tbl[entry_count] = k;
                val_tbl[entry_count] = v;
                owe(STAT_APPENDED, entry_count, k, v, 1'b1);
                entry_count++;
            end
        endfunction

        function void note_command(cmd_t c, key_t k, value_t v);
            int j;
            n_cmd[c]++;
            case (c)
                CMD_CLEAR: begin
                    entry_count = 0;
                    base_count  = 0;
                    owe(STAT_CLEARED, 0, '0, '0, 1'b1);
                end
                CMD_LOAD: begin
                    store_tuple(k, v);
                    base_count = entry_count;
                end
                CMD_MERGE: begin
                    // only base entries are searched; the first match wins
                    for (j = 0; j < base_count; j++) begin
                        if (key_tbl[j] == k) begin
                            n_hits++;
                            val_tbl[j] = clamp_sum(val_tbl[j], v, sub_mode);
                            owe(STAT_ACCUM, j, k, val_tbl[j], 1'b1);
                            return;
                        end
                    end
                    store_tuple(k, sub_mode ? clamp_sum('0, v, 1'b1) : v);
                end
                default: begin
                    if (entry_count == 0)
                        owe(STAT_EMPTY, 0, '0, '0, 1'b1);
                    else
                        for (j = 0; j < entry_count; j++)
                            owe(STAT_READ, j, key_tbl[j], val_tbl[j], j == entry_count - 1);
                end
            endcase
        endfunction

        task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] pos, key_t k,
                          value_t v, logic last);
            table_result_t want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d index %0d key %h",
                                          st, pos, k));
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            if (st !== want.status || pos !== want.position || k !== want.key ||
                v !== want.value || last !== want.last)
                report_mismatch($sformatf(
                    {"got st %0d idx %0d key %h val %h last %b",
                     " / want st %0d idx %0d key %h val %h last %b"},
                    st, pos, k, v, last, want.status, want.position, want.key, want.value,
                    want.last));
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [COMMAND_W-1:0] s_tuser   = CMD_CLEAR;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;

    merge_table_model sb;
    int  n_sent     = 0;
    int  stall_left = 0;
    bit  quiet      = 1'b0;
    bit  modes_seen[2] = '{1'b0, 1'b0};

    keyed_sparse_accumulate_merge #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random backpressure on the result side
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (quiet || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = pick_stall() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_command(cmd_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VALUE_W]);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: KEY_W],
                            m_tdata[INDEX_W+KEY_W +: VALUE_W], m_tlast);
    end

    function automatic key_t rand_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_MAX - value_t'($urandom_range(0, 1000));
            3:       return VAL_MIN + value_t'($urandom_range(0, 1000));
            4, 5, 6: return value_t'($signed({$urandom, $urandom}) >>> $urandom_range(20, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // hold valid across back-to-back transfers; drop it only for a gap
    task automatic send_cmd(cmd_t c, key_t k, value_t v);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {v, k};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(bit m);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        sb.sub_mode   = m;
        modes_seen[m] = 1'b1;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // style 0: mixed traffic, 1: fill the table past full, 2: no idling
    task automatic run_phase(int style);
        key_t pool[8];
        int   pool_n, fill, n_items, i, r;
        key_t k;
        pool_n = $urandom_range(2, 8);
        foreach (pool[i]) pool[i] = $urandom;
        wait_drained();
        write_mode($urandom_range(0, 1));
        quiet = (style == 2);
        send_cmd(CMD_CLEAR, rand_key(), rand_value());
        fill = (style == 1) ? DEPTH + $urandom_range(1, 6) : $urandom_range(2, 10);
        for (i = 0; i < fill; i++)
            send_cmd(CMD_LOAD, pool[$urandom_range(0, pool_n - 1)], rand_value());
        n_items = $urandom_range(15, 50);
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, pool_n - 1)] : rand_key();
            if (r < 60)
                send_cmd(CMD_MERGE, k, rand_value());
            else if (r < 82)
                send_cmd(CMD_LOAD, k, rand_value());
            else if (r < 92)
                send_cmd(CMD_DRAIN, rand_key(), rand_value());
            else if (r < 96)
                send_cmd(CMD_CLEAR, rand_key(), rand_value());
            else
                wait_drained();
        end
        send_cmd(CMD_DRAIN, rand_key(), rand_value());
    endtask

    initial begin
        int phase, r, n_directed;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_mode(1'b0);
        send_cmd(CMD_DRAIN, '1, VAL_MIN);                // drain of an empty table
        send_cmd(CMD_CLEAR, '0, '0);
        send_cmd(CMD_LOAD, '0, VAL_MAX);
        send_cmd(CMD_LOAD, '1, VAL_MIN);
        send_cmd(CMD_LOAD, 32'd5, value_t'(1));
        send_cmd(CMD_LOAD, 32'd5, value_t'(-7));         // duplicate key, first one wins
        send_cmd(CMD_MERGE, '0, value_t'(1));            // clamp at the top
        send_cmd(CMD_MERGE, '1, value_t'(-1));           // clamp at the bottom
        send_cmd(CMD_MERGE, 32'd5, value_t'(100));
        send_cmd(CMD_MERGE, 32'd9, VAL_MIN);             // miss, appended
        send_cmd(CMD_MERGE, 32'd9, value_t'(3));         // merged entries are not searched
        send_cmd(CMD_DRAIN, '0, '0);
        send_cmd(CMD_LOAD, 32'h1234_5678, {$urandom, $urandom});
        send_cmd(CMD_MERGE, 32'd9, value_t'(3));         // load made it searchable
        wait_drained();
        write_mode(1'b1);
        send_cmd(CMD_MERGE, '0, VAL_MIN);
        send_cmd(CMD_MERGE, '1, value_t'(1));
        send_cmd(CMD_MERGE, 32'hA5A5_A5A5, VAL_MIN);     // negation clamps
        send_cmd(CMD_MERGE, 32'h5A5A_5A5A, VAL_MAX);
        send_cmd(CMD_MERGE, 32'd5, value_t'(-100));
        send_cmd(CMD_DRAIN, '0, '0);
        send_cmd(CMD_CLEAR, '1, VAL_MAX);
        send_cmd(CMD_DRAIN, '0, '0);
        n_directed = n_sent;

        phase = 0;
        while (n_sent < n_directed + N_RANDOM) begin
            r = $urandom_range(0, 99);
            run_phase((phase == 0 || r < 15) ? 1 : (r < 35) ? 2 : 0);
            phase++;
        end
        quiet = 1'b0;
        wait_drained();
        repeat (80) @(posedge aclk);

        $display("Covered %0d commands (clear %0d, load %0d, merge %0d, drain %0d)",
                 n_sent, sb.n_cmd[CMD_CLEAR], sb.n_cmd[CMD_LOAD], sb.n_cmd[CMD_MERGE],
                 sb.n_cmd[CMD_DRAIN]);
        $display("over %0d phases; %0d results checked: %0d merge hits, %0d full-table drops,",
                 phase, sb.n_checked, sb.n_hits, sb.n_dropped);
        $display("%0d clamped, modes %0d/%0d", sb.n_sat, modes_seen[0], modes_seen[1]);
        if (sb.n_mismatch == 0 && sb.owed_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timeout with %0d results still owed", sb.owed_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/ksam_pkg.sv
hdl/ksam_ctrl.sv
hdl/ksam_dp.sv
hdl/keyed_sparse_accumulate_merge.sv
verif/keyed_sparse_accumulate_merge_tb.sv
